// ----- rtl/core/cfrx_pkg.sv -----
`timescale 1ns / 1ps

package cfrx_pkg;

   localparam int ID_W      = 11;
   localparam int LEN_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int WORD_W    = 32;
   localparam int INDEX_W   = 4;
   localparam int CSR_IDX_W = 4;

   localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_TXID   = 4'd0,
      REG_TXDLC  = 4'd1,
      REG_TXD0   = 4'd2,
      REG_TXD1   = 4'd3,
      REG_SEND   = 4'd4,
      REG_RXID   = 4'd5,
      REG_RXDLC  = 4'd6,
      REG_RXD0   = 4'd7,
      REG_RXD1   = 4'd8,
      REG_POP    = 4'd9,
      REG_STATUS = 4'd10,
      REG_FID    = 4'd11,
      REG_FMASK  = 4'd12
   } reg_index_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ID   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MASK = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]     length;
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
   } fifo_entry_type;

endpackage

// ----- rtl/core/can_frame_controller_with_rx_fifo_unit.sv -----
`timescale 1ns / 1ps

// can frame controller with acceptance filter and receive fifo
// req channel: one item is a register read, a register write, a frame
//   arriving from the bus or a no-op; rsp channel: exactly one result item per request
// csr port: filter id (index 0) and filter mask (index 1), written any cycle
//   with csr_wr_en, no wait states
// the block takes one item at a time and accepts no new one until the result
//   is taken: ST_IDLE accepts the item, ST_EXEC reads the head entry from the
//   fifo memory and updates state, ST_RESP presents the registered result
// the fifo lives in a synchronous memory read every cycle at the head
//   pointer; every write or pop lands at the end of the execute state, ahead of the
//   next accept, so the head data is always current in the execute cycle
// stall: while rsp_ready is low the result holds and req_ready stays low
// reset: transmit registers, filters, pointers, fill count and flags clear;
//   fifo memory contents are not cleared, entries are read only after write
module can_frame_controller_with_rx_fifo_unit #(
   parameter int FIFO_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [cfrx_pkg::INDEX_W-1:0]        req_reg_index,
   input  logic [cfrx_pkg::WORD_W-1:0]         req_write_value,
   input  logic [cfrx_pkg::ID_W-1:0]           req_arriving_id,
   input  logic [cfrx_pkg::LEN_W-1:0]          req_arriving_length,
   input  logic [cfrx_pkg::PAYLOAD_W-1:0]      req_arriving_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cfrx_pkg::WORD_W-1:0]         rsp_read_value,
   output logic                                rsp_send_strobe,
   output logic [cfrx_pkg::ID_W-1:0]           rsp_send_id,
   output logic [cfrx_pkg::LEN_W-1:0]          rsp_send_length,
   output logic [cfrx_pkg::PAYLOAD_W-1:0]      rsp_send_payload,
   output logic                                rsp_frame_accepted,
   input  logic                                csr_wr_en,
   input  logic [cfrx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfrx_pkg::ID_W-1:0]           csr_wr_data
);

   localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FIFO_DEPTH);
   localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(1);

   localparam int ID_W  = cfrx_pkg::ID_W;
   localparam int LEN_W = cfrx_pkg::LEN_W;
   localparam int PAY_W = cfrx_pkg::PAYLOAD_W;
   localparam int WRD_W = cfrx_pkg::WORD_W;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   cfrx_pkg::state_type state_ff, state_in;
   logic ld_item, do_exec;

   cfrx_pkg::action_type     act_ff;
   cfrx_pkg::reg_index_type  idx_ff;
   logic [WRD_W-1:0]         val_ff;
   cfrx_pkg::fifo_entry_type arr_ff;

   logic [ID_W-1:0]   fid_ff, fid_in, fmask_ff, fmask_in;
   logic [ID_W-1:0]   txid_ff, txid_in;
   logic [LEN_W-1:0]  txlen_ff, txlen_in;
   logic [PAY_W-1:0]  txpay_ff, txpay_in;
   logic [PTR_W-1:0]  rdp_ff, rdp_in, wrp_ff, wrp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              txok_ff, txok_in, ovf_ff, ovf_in;

   logic [WRD_W-1:0]  rval_ff, rval_in;
   logic              sstb_ff, sstb_in;
   logic [ID_W-1:0]   sid_ff, sid_in;
   logic [LEN_W-1:0]  slen_ff, slen_in;
   logic [PAY_W-1:0]  spay_ff, spay_in;
   logic              facc_ff, facc_in;

   logic                     push;
   logic                     have;
   logic                     pass;
   cfrx_pkg::fifo_entry_type head;

   cfrx_fifo_mem #(
      .DEPTH (FIFO_DEPTH),
      .PTR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wrp_ff),
      .wr_data (arr_ff),
      .rd_addr (rdp_ff),
      .rd_data (head)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfrx_pkg::ST_IDLE: if (req_valid) state_in = cfrx_pkg::ST_EXEC;
         cfrx_pkg::ST_EXEC: state_in = cfrx_pkg::ST_RESP;
         cfrx_pkg::ST_RESP: if (rsp_ready) state_in = cfrx_pkg::ST_IDLE;
         default:           state_in = cfrx_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      do_exec   = 1'b0;
      unique case (state_ff)
         cfrx_pkg::ST_IDLE: req_ready = 1'b1;
         cfrx_pkg::ST_EXEC: do_exec   = 1'b1;
         cfrx_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign ld_item = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfrx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_item) begin
         act_ff         <= cfrx_pkg::action_type'(req_action);
         idx_ff         <= cfrx_pkg::reg_index_type'(req_reg_index);
         val_ff         <= req_write_value;
         arr_ff.id      <= req_arriving_id;
         arr_ff.length  <= req_arriving_length;
         arr_ff.payload <= req_arriving_payload;
      end
   end

   assign have = (fill_ff != '0);
   assign pass = (((arr_ff.id ^ fid_ff) & fmask_ff) == '0);
   assign push = do_exec && (act_ff == cfrx_pkg::ACT_FRAME) && pass && (fill_ff != FILL_FULL);

   // execute step, plus csr filter writes
   always_comb begin
      fid_in   = fid_ff;
      fmask_in = fmask_ff;
      txid_in  = txid_ff;
      txlen_in = txlen_ff;
      txpay_in = txpay_ff;
      rdp_in   = rdp_ff;
      wrp_in   = wrp_ff;
      fill_in  = fill_ff;
      txok_in  = txok_ff;
      ovf_in   = ovf_ff;
      rval_in  = '0;
      sstb_in  = 1'b0;
      sid_in   = '0;
      slen_in  = '0;
      spay_in  = '0;
      facc_in  = 1'b0;
      if (do_exec) begin
         unique case (act_ff)
            cfrx_pkg::ACT_READ: begin
               unique case (idx_ff)
                  cfrx_pkg::REG_TXID:   rval_in = WRD_W'(txid_ff);
                  cfrx_pkg::REG_TXDLC:  rval_in = WRD_W'(txlen_ff);
                  cfrx_pkg::REG_TXD0:   rval_in = txpay_ff[WRD_W-1:0];
                  cfrx_pkg::REG_TXD1:   rval_in = txpay_ff[PAY_W-1:WRD_W];
                  cfrx_pkg::REG_RXID:   rval_in = have ? WRD_W'(head.id) : '0;
                  cfrx_pkg::REG_RXDLC:  rval_in = have ? WRD_W'(head.length) : '0;
                  cfrx_pkg::REG_RXD0:   rval_in = have ? head.payload[WRD_W-1:0] : '0;
                  cfrx_pkg::REG_RXD1:   rval_in = have ? head.payload[PAY_W-1:WRD_W] : '0;
                  cfrx_pkg::REG_STATUS: rval_in = WRD_W'({ovf_ff, have, txok_ff});
                  cfrx_pkg::REG_FID:    rval_in = WRD_W'(fid_ff);
                  cfrx_pkg::REG_FMASK:  rval_in = WRD_W'(fmask_ff);
                  default:              rval_in = '0;
               endcase
            end
            cfrx_pkg::ACT_WRITE: begin
               unique case (idx_ff)
                  cfrx_pkg::REG_TXID:  txid_in = val_ff[ID_W-1:0];
                  cfrx_pkg::REG_TXDLC: begin
                     txlen_in = (val_ff[LEN_W-1:0] > cfrx_pkg::LEN_MAX) ?
                                cfrx_pkg::LEN_MAX : val_ff[LEN_W-1:0];
                  end
                  cfrx_pkg::REG_TXD0:  txpay_in[WRD_W-1:0]     = val_ff;
                  cfrx_pkg::REG_TXD1:  txpay_in[PAY_W-1:WRD_W] = val_ff;
                  cfrx_pkg::REG_SEND: begin
                     sstb_in = 1'b1;
                     sid_in  = txid_ff;
                     slen_in = txlen_ff;
                     spay_in = txpay_ff;
                     txok_in = 1'b1;
                  end
                  cfrx_pkg::REG_POP: begin
                     if (have) begin
                        rdp_in  = bump(rdp_ff);
                        fill_in = fill_ff - FILL_ONE;
                     end
                  end
                  cfrx_pkg::REG_FID:   fid_in   = val_ff[ID_W-1:0];
                  cfrx_pkg::REG_FMASK: fmask_in = val_ff[ID_W-1:0];
                  default: ;
               endcase
            end
            cfrx_pkg::ACT_FRAME: begin
               if (pass) begin
                  if (fill_ff == FILL_FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     wrp_in  = bump(wrp_ff);
                     fill_in = fill_ff + FILL_ONE;
                     facc_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (csr_wr_en) begin
         if (csr_index == cfrx_pkg::CSR_FILTER_ID) begin
            fid_in = csr_wr_data;
         end else if (csr_index == cfrx_pkg::CSR_FILTER_MASK) begin
            fmask_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fid_ff   <= '0;
         fmask_ff <= '0;
         txid_ff  <= '0;
         txlen_ff <= '0;
         txpay_ff <= '0;
         rdp_ff   <= '0;
         wrp_ff   <= '0;
         fill_ff  <= '0;
         txok_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         fid_ff   <= fid_in;
         fmask_ff <= fmask_in;
         txid_ff  <= txid_in;
         txlen_ff <= txlen_in;
         txpay_ff <= txpay_in;
         rdp_ff   <= rdp_in;
         wrp_ff   <= wrp_in;
         fill_ff  <= fill_in;
         txok_ff  <= txok_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_exec) begin
         rval_ff <= rval_in;
         sstb_ff <= sstb_in;
         sid_ff  <= sid_in;
         slen_ff <= slen_in;
         spay_ff <= spay_in;
         facc_ff <= facc_in;
      end
   end

   assign rsp_read_value     = rval_ff;
   assign rsp_send_strobe    = sstb_ff;
   assign rsp_send_id        = sid_ff;
   assign rsp_send_length    = slen_ff;
   assign rsp_send_payload   = spay_ff;
   assign rsp_frame_accepted = facc_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fifo fill count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (rdp_ff == wrp_ff))
      else $error("empty fifo with unequal pointers");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item in flight");

   a_ovf_on_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> ($past(fill_ff) == FILL_FULL))
      else $error("overflow flagged with room in fifo");

endmodule

// ----- rtl/core/cfrx_fifo_mem.sv -----
`timescale 1ns / 1ps

module cfrx_fifo_mem #(
   parameter int DEPTH = 8,
   parameter int PTR_W = 3
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [PTR_W-1:0]        wr_addr,
   input  cfrx_pkg::fifo_entry_type wr_data,
   input  logic [PTR_W-1:0]        rd_addr,
   output cfrx_pkg::fifo_entry_type rd_data
);

   cfrx_pkg::fifo_entry_type mem_ff [DEPTH];
   cfrx_pkg::fifo_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/can_frame_controller_with_rx_fifo_unit_test.sv -----
`timescale 1ns / 1ps

module can_frame_controller_with_rx_fifo_unit_test;

   localparam int RX_DEPTH      = 8;
   localparam int RX_PTR_W      = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;
   localparam int FLAG_TXOK     = 0;
   localparam int FLAG_RXREADY  = 1;
   localparam int FLAG_OVERFLOW = 2;

   localparam int ID_W      = cfrx_pkg::ID_W;
   localparam int LEN_W     = cfrx_pkg::LEN_W;
   localparam int PAYLOAD_W = cfrx_pkg::PAYLOAD_W;
   localparam int WORD_W    = cfrx_pkg::WORD_W;
   localparam int INDEX_W   = cfrx_pkg::INDEX_W;
   localparam int CSR_IDX_W = cfrx_pkg::CSR_IDX_W;

   typedef struct {
      cfrx_pkg::action_type   action;
      logic [INDEX_W-1:0]     reg_index;
      logic [WORD_W-1:0]      write_value;
      logic [ID_W-1:0]        arriving_id;
      logic [LEN_W-1:0]       arriving_length;
      logic [PAYLOAD_W-1:0]   arriving_payload;
   } can_access_type;

   typedef struct {
      logic [WORD_W-1:0]      read_value;
      logic                   send_strobe;
      logic [ID_W-1:0]        send_id;
      logic [LEN_W-1:0]       send_length;
      logic [PAYLOAD_W-1:0]   send_payload;
      logic                   frame_accepted;
   } can_result_type;

   class can_scoreboard_type;
      logic [ID_W-1:0]      match_id = '0;
      logic [ID_W-1:0]      match_mask = '0;
      logic [ID_W-1:0]      tx_ident = '0;
      logic [LEN_W-1:0]     tx_dlc = '0;
      logic [PAYLOAD_W-1:0] tx_data = '0;
      logic [ID_W-1:0]      rx_ident [RX_DEPTH];
      logic [LEN_W-1:0]     rx_dlc [RX_DEPTH];
      logic [PAYLOAD_W-1:0] rx_data [RX_DEPTH];
      logic [RX_PTR_W-1:0]  head = '0;
      logic [RX_PTR_W-1:0]  tail = '0;
      int                   count = 0;
      logic [2:0]           flags = '0;
      can_result_type       owed [$];
      int                   mismatches = 0;

      function logic [RX_PTR_W-1:0] next_ptr(logic [RX_PTR_W-1:0] p);
         return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
      endfunction

      function logic [WORD_W-1:0] read_register(logic [INDEX_W-1:0] idx);
         logic [WORD_W-1:0] v;
         v = '0;
         case (idx)
            cfrx_pkg::REG_TXID:   v = WORD_W'(tx_ident);
            cfrx_pkg::REG_TXDLC:  v = WORD_W'(tx_dlc);
            cfrx_pkg::REG_TXD0:   v = tx_data[31:0];
            cfrx_pkg::REG_TXD1:   v = tx_data[63:32];
            cfrx_pkg::REG_RXID:   if (count > 0) v = WORD_W'(rx_ident[head]);
            cfrx_pkg::REG_RXDLC:  if (count > 0) v = WORD_W'(rx_dlc[head]);
            cfrx_pkg::REG_RXD0:   if (count > 0) v = rx_data[head][31:0];
            cfrx_pkg::REG_RXD1:   if (count > 0) v = rx_data[head][63:32];
            cfrx_pkg::REG_STATUS: v = WORD_W'(flags);
            cfrx_pkg::REG_FID:    v = WORD_W'(match_id);
            cfrx_pkg::REG_FMASK:  v = WORD_W'(match_mask);
            default:              v = '0;
         endcase
         return v;
      endfunction

      function can_result_type apply_access(can_access_type a);
         can_result_type r;
         r = '{default: '0};
         case (a.action)
            cfrx_pkg::ACT_READ: r.read_value = read_register(a.reg_index);
            cfrx_pkg::ACT_WRITE: begin
               case (a.reg_index)
                  cfrx_pkg::REG_TXID:  tx_ident = a.write_value[ID_W-1:0];
                  cfrx_pkg::REG_TXDLC: begin
                     tx_dlc = (a.write_value[LEN_W-1:0] > cfrx_pkg::LEN_MAX) ?
                              cfrx_pkg::LEN_MAX : a.write_value[LEN_W-1:0];
                  end
                  cfrx_pkg::REG_TXD0:  tx_data[31:0] = a.write_value;
                  cfrx_pkg::REG_TXD1:  tx_data[63:32] = a.write_value;
                  cfrx_pkg::REG_SEND: begin
                     r.send_strobe = 1'b1;
                     r.send_id = tx_ident;
                     r.send_length = tx_dlc;
                     r.send_payload = tx_data;
                     flags[FLAG_TXOK] = 1'b1;
                  end
                  cfrx_pkg::REG_POP: begin
                     if (count > 0) begin
                        head = next_ptr(head);
                        count--;
                        if (count == 0) flags[FLAG_RXREADY] = 1'b0;
                     end
                  end
                  cfrx_pkg::REG_FID:   match_id = a.write_value[ID_W-1:0];
                  cfrx_pkg::REG_FMASK: match_mask = a.write_value[ID_W-1:0];
                  default: ;
               endcase
            end
            cfrx_pkg::ACT_FRAME: begin
               if (((a.arriving_id ^ match_id) & match_mask) == '0) begin
                  if (count >= RX_DEPTH) begin
                     flags[FLAG_OVERFLOW] = 1'b1;
                  end else begin
                     rx_ident[tail] = a.arriving_id;
                     rx_dlc[tail] = a.arriving_length;
                     rx_data[tail] = a.arriving_payload;
                     tail = next_ptr(tail);
                     count++;
                     flags[FLAG_RXREADY] = 1'b1;
                     r.frame_accepted = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void take_access(can_access_type a);
         owed.push_back(apply_access(a));
      endfunction

      function void check_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%s mismatch: expected %h, got %h", field, want, got);
         end
      endfunction

      function void compare_output(can_result_type got);
         can_result_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result with no access pending: read_value %h", got.read_value);
         end else begin
            want = owed.pop_front();
            check_field("read_value", 64'(want.read_value), 64'(got.read_value));
            check_field("send_strobe", 64'(want.send_strobe), 64'(got.send_strobe));
            check_field("send_id", 64'(want.send_id), 64'(got.send_id));
            check_field("send_length", 64'(want.send_length), 64'(got.send_length));
            check_field("send_payload", want.send_payload, got.send_payload);
            check_field("frame_accepted", 64'(want.frame_accepted),
                        64'(got.frame_accepted));
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_action = '0;
   logic [INDEX_W-1:0]     req_reg_index = '0;
   logic [WORD_W-1:0]      req_write_value = '0;
   logic [ID_W-1:0]        req_arriving_id = '0;
   logic [LEN_W-1:0]       req_arriving_length = '0;
   logic [PAYLOAD_W-1:0]   req_arriving_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [WORD_W-1:0]      rsp_read_value;
   logic                   rsp_send_strobe;
   logic [ID_W-1:0]        rsp_send_id;
   logic [LEN_W-1:0]       rsp_send_length;
   logic [PAYLOAD_W-1:0]   rsp_send_payload;
   logic                   rsp_frame_accepted;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [ID_W-1:0]        csr_wr_data = '0;

   can_scoreboard_type sb = new();
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int cycles = 0;

   can_frame_controller_with_rx_fifo_unit #(
      .FIFO_DEPTH(RX_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_reg_index(req_reg_index),
      .req_write_value(req_write_value),
      .req_arriving_id(req_arriving_id),
      .req_arriving_length(req_arriving_length),
      .req_arriving_payload(req_arriving_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_send_strobe(rsp_send_strobe),
      .rsp_send_id(rsp_send_id),
      .rsp_send_length(rsp_send_length),
      .rsp_send_payload(rsp_send_payload),
      .rsp_frame_accepted(rsp_frame_accepted),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.compare_output('{read_value: rsp_read_value, send_strobe: rsp_send_strobe,
                             send_id: rsp_send_id, send_length: rsp_send_length,
                             send_payload: rsp_send_payload,
                             frame_accepted: rsp_frame_accepted});
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic can_access_type reg_access(cfrx_pkg::action_type act,
                                                 logic [INDEX_W-1:0] idx,
                                                 logic [WORD_W-1:0] val);
      can_access_type a;
      a.action = act;
      a.reg_index = idx;
      a.write_value = val;
      a.arriving_id = ID_W'($urandom);
      a.arriving_length = LEN_W'($urandom);
      a.arriving_payload = {$urandom, $urandom};
      return a;
   endfunction

   function automatic can_access_type arriving(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                               logic [PAYLOAD_W-1:0] payload);
      can_access_type a;
      a = reg_access(cfrx_pkg::ACT_FRAME, INDEX_W'($urandom), $urandom);
      a.arriving_id = id;
      a.arriving_length = len;
      a.arriving_payload = payload;
      return a;
   endfunction

   // alternate fill-heavy and pop-heavy stretches so the fifo swings empty to full
   function automatic can_access_type random_access(int n);
      can_access_type a;
      int pick;
      int frame_pct;
      int pop_pct;
      frame_pct = ((n / 24) % 2 == 1) ? 15 : 40;
      pop_pct = ((n / 24) % 2 == 1) ? 35 : 8;
      pick = $urandom_range(99);
      a = reg_access(cfrx_pkg::ACT_NONE, INDEX_W'($urandom), $urandom);
      if (pick < frame_pct) begin
         a.action = cfrx_pkg::ACT_FRAME;
         if ($urandom_range(9) < 7)
            a.arriving_id = (sb.match_id & sb.match_mask) | (a.arriving_id & ~sb.match_mask);
         if ($urandom_range(9) < 8)
            a.arriving_length = LEN_W'($urandom_range(cfrx_pkg::LEN_MAX));
      end else if (pick < frame_pct + pop_pct) begin
         a.action = cfrx_pkg::ACT_WRITE;
         a.reg_index = cfrx_pkg::REG_POP;
      end else if (pick < frame_pct + pop_pct + 25) begin
         a.action = cfrx_pkg::ACT_READ;
         if ($urandom_range(1) == 1)
            a.reg_index = INDEX_W'($urandom_range(cfrx_pkg::REG_RXD1, cfrx_pkg::REG_RXID));
      end else if (pick < 94) begin
         a.action = cfrx_pkg::ACT_WRITE;
         a.reg_index = INDEX_W'($urandom_range(cfrx_pkg::REG_SEND, cfrx_pkg::REG_TXID));
         if ($urandom_range(1) == 1)
            a.write_value = WORD_W'($urandom_range(15));
      end else if (pick < 98) begin
         a.action = cfrx_pkg::ACT_WRITE;
      end
      return a;
   endfunction

   task automatic issue(input can_access_type a);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_action <= a.action;
      req_reg_index <= a.reg_index;
      req_write_value <= a.write_value;
      req_arriving_id <= a.arriving_id;
      req_arriving_length <= a.arriving_length;
      req_arriving_payload <= a.arriving_payload;
      do @(posedge clock); while (!req_ready);
      sb.take_access(a);
   endtask

   task automatic drain();
      do @(posedge clock); while (sb.owed.size() != 0);
   endtask

   task automatic set_filters(input logic [ID_W-1:0] fid, input logic [ID_W-1:0] fmask);
      csr_wr_en <= 1'b1;
      csr_index <= cfrx_pkg::CSR_FILTER_ID;
      csr_wr_data <= fid;
      @(posedge clock);
      csr_index <= cfrx_pkg::CSR_FILTER_MASK;
      csr_wr_data <= fmask;
      @(posedge clock);
      // index past the filters, must be ignored
      csr_index <= CSR_IDX_W'($urandom_range(2**CSR_IDX_W - 1,
                                             cfrx_pkg::CSR_FILTER_MASK + 1));
      csr_wr_data <= ID_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.match_id = fid;
      sb.match_mask = fmask;
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct,
                            input logic [ID_W-1:0] fid, input logic [ID_W-1:0] fmask,
                            input int items);
      int n;
      set_filters(fid, fmask);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < items; n++) begin
         if (n == items / 2) begin
            req_valid <= 1'b0;
            drain();
         end
         issue(random_access(n));
      end
      req_valid <= 1'b0;
      drain();
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_filters('1, '0);

      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_STATUS, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_RXID, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_RXD1, '0));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_POP, '0));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_TXID, '1));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_TXDLC, '1));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_TXD0, '1));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_TXD1, 32'h8000_0001));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_SEND, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_TXDLC, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_SEND, '0));
      issue(arriving('0, '0, '0));
      issue(arriving('1, '1, '1));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_POP, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_RXDLC, '0));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_RXD1, '0));
      issue(reg_access(cfrx_pkg::ACT_WRITE, cfrx_pkg::REG_STATUS, '1));
      issue(reg_access(cfrx_pkg::ACT_WRITE, '1, '1));
      issue(reg_access(cfrx_pkg::ACT_NONE, cfrx_pkg::REG_TXID, '1));
      // one entry still queued, so the last of these overflows
      for (n = 0; n < RX_DEPTH; n++)
         issue(arriving(ID_W'(n), LEN_W'(n), {$urandom, $urandom}));
      issue(reg_access(cfrx_pkg::ACT_READ, cfrx_pkg::REG_STATUS, '0));
      req_valid <= 1'b0;
      drain();

      run_phase(30, 78, '0, '1, 150);
      run_phase(78, 30, '1, '1, 150);
      run_phase(0, 0, ID_W'($urandom), ID_W'($urandom), 150);

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/cfrx_pkg.sv
rtl/core/cfrx_fifo_mem.sv
rtl/core/can_frame_controller_with_rx_fifo_unit.sv
tb/can_frame_controller_with_rx_fifo_unit_test.sv
